[rtl/bgbd_pkg.sv]
// Shared constants, types and the LED count table of the battery gauge bar display.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bgbd_pkg;

  // Block dimensions.
  localparam int unsigned WINDOW_SIZE = 1000;
  localparam int unsigned BAR_LEDS    = 6;
  localparam int unsigned ADC_BITS    = 12;

  // Field widths fixed by the interface.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned LIT_W      = 3;
  localparam int unsigned COLOR_W    = 2;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = 2 * PCT_W + LIT_W + COLOR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int unsigned PCT_MAX = 100;
  localparam int unsigned ADC_TOP = (1 << ADC_BITS) - 1;

  // Arithmetic widths.
  localparam int unsigned PROD_W     = ADC_BITS + MV_W;
  localparam int unsigned NUM_W      = PROD_W;
  localparam int unsigned DEN_W      = MV_W;
  localparam int unsigned STEP_W     = $clog2(NUM_W + 1);
  localparam int unsigned MUL_CNT_W  = $clog2(ADC_BITS + 1);
  localparam int unsigned PCT_NUM_W  = MV_W + PCT_W;
  localparam int unsigned PTR_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned FILL_W     = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned LED_CNT_W  = $clog2(BAR_LEDS + 1);
  localparam int unsigned LED_PROD_W = $clog2(BAR_LEDS * 127 + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MV_FULL_SCALE = 3'd0,
    REG_EMPTY_MV      = 3'd1,
    REG_FULL_MV       = 3'd2,
    REG_RED_LIMIT     = 3'd3,
    REG_YELLOW_LIMIT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [COLOR_W-1:0] {
    BAR_OFF    = 2'd0,
    BAR_RED    = 2'd1,
    BAR_YELLOW = 2'd2,
    BAR_GREEN  = 2'd3
  } bar_color_e;

  typedef struct packed {
    logic                start;
    logic [ADC_BITS-1:0] a;
    logic [MV_W-1:0]     b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  // Number of lit LEDs: floor(BAR_LEDS * avg / 100), found by comparing
  // against each LED threshold in parallel.
  function automatic logic [LIT_W-1:0] lit_of(input logic [PCT_W-1:0] avg);
    logic [LED_PROD_W-1:0] scaled;
    logic [LED_CNT_W-1:0]  n;
    scaled = LED_PROD_W'(BAR_LEDS) * LED_PROD_W'(avg);
    n      = '0;
    for (int k = 1; k <= BAR_LEDS; k++) begin
      if (scaled >= LED_PROD_W'(k * PCT_MAX)) begin
        n = LED_CNT_W'(k);
      end
    end
    return LIT_W'(n);
  endfunction

endpackage

`default_nettype wire

[rtl/bgbd_serial_mul.sv]
// Bit-serial shift-and-add multiplier: sample times millivolt scale, one
// multiplier bit per cycle. Depends on bgbd_pkg.
`default_nettype none

module bgbd_serial_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bgbd_pkg::mul_req_t       req_i,
  output logic                     done_o,
  output logic [bgbd_pkg::PROD_W-1:0] prod_o
);
  import bgbd_pkg::*;

  logic [MV_W-1:0]      hi_q, hi_d, m_q;
  logic [ADC_BITS-1:0]  lo_q, lo_d;
  logic [MV_W:0]        sum;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;

  always_comb begin
    sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, m_q} : '0);
    hi_d = sum[MV_W:1];
    lo_d = {sum[0], lo_q[ADC_BITS-1:1]};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = MUL_CNT_W'(ADC_BITS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q <= '0;
      lo_q <= req_i.a;
      m_q  <= req_i.b;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

[rtl/bgbd_serial_div.sv]
// Restoring divider that produces one quotient bit per cycle; shared by the
// millivolt, percent and average divisions. Depends on bgbd_pkg.
`default_nettype none

module bgbd_serial_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bgbd_pkg::div_req_t         req_i,
  output logic                       done_o,
  output logic [bgbd_pkg::NUM_W-1:0] quot_o
);
  import bgbd_pkg::*;

  // The dividend is aligned to the top of num_q; quotient bits enter at the
  // bottom as dividend bits leave at the top.
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  rem_q, rem_d, den_q;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;
  logic              take;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    take    = !diff[DEN_W+1];
    rem_d   = take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    num_d   = {num_q[NUM_W-2:0], take};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

[rtl/bgbd_ring.sv]
// Ring memory of the last percents of the averaging window, one write and one
// registered read port. Depends on bgbd_pkg.
`default_nettype none

module bgbd_ring (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [bgbd_pkg::PTR_W-1:0] waddr_i,
  input  logic [bgbd_pkg::PCT_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [bgbd_pkg::PTR_W-1:0] raddr_i,
  output logic [bgbd_pkg::PCT_W-1:0] rdata_o
);
  import bgbd_pkg::*;

  logic [PCT_W-1:0] mem_q [WINDOW_SIZE];
  logic [PCT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/battery_gauge_bar_display.sv]
// Top level of the battery gauge bar display: sequencer, window state and
// result register. Depends on bgbd_pkg, bgbd_serial_mul, bgbd_serial_div, bgbd_ring.
`default_nettype none

// Each transaction on the input stream carries one raw battery converter sample.
// The block scales it to millivolts as floor(sample * full scale / 4095), maps
// that onto a charge percent between the empty and full voltages (clamped to
// 0..100, and 0 whenever full is not above empty), and keeps a moving average
// over the last 1000 percents; until the window is full the average is taken
// over the samples seen so far. Every input transaction yields exactly one
// output transaction holding the instant percent, the average percent, the
// number of the six bar LEDs that light and the colour class of the bar. One
// sample is processed at a time: the next is taken once the current result is
// loaded into the output register. The percent division is skipped when the
// millivolts are at or below empty or full is not above empty. The datapath is
// bit-serial: a shift-and-add multiplier and a single restoring divider that
// yields one quotient bit per cycle and is shared by the millivolt, percent
// and average divisions. A finished result waits in an output register, so
// the next sample is accepted and worked on while the previous result is
// still pending downstream. Configuration registers are written through a
// plain write port and must only be changed while no transaction is in
// flight; writes to unused indexes are ignored. The window memory needs no
// clearing after reset, since an entry's value is only used once it is written.

module battery_gauge_bar_display (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [11:0] adc_sample, [15:12] zero.
  input  logic [bgbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [6:0] instant_percent, [13:7] average_percent, [16:14] lit_count,
  // [18:17] bar_color, [23:19] zero.
  output logic [bgbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [bgbd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bgbd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bgbd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_MUL     = 7'b0000010,
    ST_DIV_MV  = 7'b0000100,
    ST_DIV_PCT = 7'b0001000,
    ST_SUM     = 7'b0010000,
    ST_DIV_AVG = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [MV_W-1:0]  scale_q, empty_q, full_q;
  logic [PCT_W-1:0] red_q, yellow_q;

  // Window state.
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  // Per-sample working values.
  logic [PCT_W-1:0] pct_q, pct_d, avg_q, avg_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic [PCT_W-1:0]   out_pct_q, out_avg_q;
  logic [LIT_W-1:0]   out_lit_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_load;

  // Datapath units.
  mul_req_t           mul_req;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;
  div_req_t           div_req;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic               ring_we;
  logic [PCT_W-1:0]   ring_rdata;

  logic                 in_fire;
  logic [MV_W-1:0]      sample_wide;
  logic [MV_W-1:0]      mv, mv_diff, span;
  logic                 pct_needed;
  logic [PCT_NUM_W-1:0] pct_num;
  logic [PCT_W-1:0]     quot_clamped;
  logic                 window_full;
  bar_color_e           color;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign sample_wide   = MV_W'(s_axis_tdata[SAMPLE_W-1:0]);

  // Millivolt result and the percent numerator (mv - empty) * 100.
  assign mv         = div_quot[MV_W-1:0];
  assign mv_diff    = mv - empty_q;
  assign span       = full_q - empty_q;
  assign pct_needed = (full_q > empty_q) && (mv > empty_q);
  assign pct_num    = PCT_NUM_W'(mv_diff) * PCT_NUM_W'(PCT_MAX);

  assign quot_clamped = (div_quot > NUM_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                     : div_quot[PCT_W-1:0];
  assign window_full  = (fill_q == FILL_W'(WINDOW_SIZE));

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    mul_req.start = in_fire;
    mul_req.a     = sample_wide[ADC_BITS-1:0];
    mul_req.b     = scale_q;
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(NUM_W);
    div_req.num   = mul_prod;
    div_req.den   = DEN_W'(ADC_TOP);
    pct_d         = pct_q;
    avg_d         = avg_q;
    wp_d          = wp_q;
    fill_d        = fill_q;
    sum_d         = sum_q;
    ring_we       = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV_MV;
        end
      end
      ST_DIV_MV: begin
        if (div_done) begin
          if (pct_needed) begin
            div_req.start = 1'b1;
            div_req.steps = STEP_W'(PCT_NUM_W);
            div_req.num   = NUM_W'(pct_num) << (NUM_W - PCT_NUM_W);
            div_req.den   = span;
            state_d       = ST_DIV_PCT;
          end else begin
            pct_d   = '0;
            state_d = ST_SUM;
          end
        end
      end
      ST_DIV_PCT: begin
        if (div_done) begin
          pct_d   = quot_clamped;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        // Once the window is full the oldest percent, fetched at acceptance,
        // leaves the sum before its entry is overwritten.
        if (window_full) begin
          sum_d = sum_q - SUM_W'(ring_rdata) + SUM_W'(pct_q);
        end else begin
          sum_d  = sum_q + SUM_W'(pct_q);
          fill_d = fill_q + 1'b1;
        end
        ring_we = 1'b1;
        wp_d    = (wp_q == PTR_W'(WINDOW_SIZE - 1)) ? '0 : wp_q + 1'b1;
        div_req.start = 1'b1;
        div_req.steps = STEP_W'(SUM_W);
        div_req.num   = NUM_W'(sum_d) << (NUM_W - SUM_W);
        div_req.den   = DEN_W'(fill_d);
        state_d       = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          avg_d   = quot_clamped;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Colour class; red is tested before yellow as the limits are written.
  always_comb begin
    priority if (avg_q == '0) begin
      color = BAR_OFF;
    end else if (avg_q < red_q) begin
      color = BAR_RED;
    end else if (avg_q < yellow_q) begin
      color = BAR_YELLOW;
    end else begin
      color = BAR_GREEN;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= MV_W'(7128);
      empty_q  <= MV_W'(3200);
      full_q   <= MV_W'(4200);
      red_q    <= PCT_W'(30);
      yellow_q <= PCT_W'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MV_FULL_SCALE: scale_q  <= cfg_data_i;
        REG_EMPTY_MV:      empty_q  <= cfg_data_i;
        REG_FULL_MV:       full_q   <= cfg_data_i;
        REG_RED_LIMIT:     red_q    <= cfg_data_i[PCT_W-1:0];
        REG_YELLOW_LIMIT:  yellow_q <= cfg_data_i[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pct_q <= pct_d;
    avg_q <= avg_d;
    if (out_load) begin
      out_pct_q   <= pct_q;
      out_avg_q   <= avg_q;
      out_lit_q   <= lit_of(avg_q);
      out_color_q <= color;
    end
  end

  bgbd_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  bgbd_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // The oldest entry is read when the sample is accepted and used in ST_SUM.
  bgbd_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wp_q),
    .wdata_i (pct_q),
    .re_i    (in_fire),
    .raddr_i (wp_q),
    .rdata_o (ring_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_color_q, out_lit_q, out_avg_q, out_pct_q});

endmodule

`default_nettype wire

[rtl/bgbd_checker.sv]
// Port-level checker of the battery gauge bar display and its bind statement.
// Depends on bgbd_pkg and battery_gauge_bar_display.
`default_nettype none

module bgbd_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [bgbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we_i
);
  import bgbd_pkg::*;

  logic [PCT_W-1:0]   inst_pct, avg_pct;
  logic [LIT_W-1:0]   lit;
  logic [COLOR_W-1:0] colour;

  assign inst_pct = m_axis_tdata[PCT_W-1:0];
  assign avg_pct  = m_axis_tdata[2*PCT_W-1:PCT_W];
  assign lit      = m_axis_tdata[2*PCT_W+LIT_W-1:2*PCT_W];
  assign colour   = m_axis_tdata[OUT_FIELD_W-1:2*PCT_W+LIT_W];

  // A pending result transaction holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  // Samples are worked one at a time: no input straight after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in progress");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inst_pct <= PCT_W'(PCT_MAX) && avg_pct <= PCT_W'(PCT_MAX))
    else $error("percent out of range");

  // Colour is none exactly when the average is zero, and the LED count fits.
  a_bar_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((colour == '0) == (avg_pct == '0)) &&
                      (LED_CNT_W'(lit) <= LED_CNT_W'(BAR_LEDS)))
    else $error("bar fields inconsistent with the average");

  // Registers are only written while the block holds no transaction.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> s_axis_tready && !m_axis_tvalid)
    else $error("configuration written while a transaction is in flight");

endmodule

bind battery_gauge_bar_display bgbd_checker u_bgbd_checker (.*);

`default_nettype wire

[bench/battery_gauge_bar_display_test.sv]
// Self-checking testbench for the battery gauge bar display: streams converter samples
// through the block under several gauge settings and checks every result transaction.
// Depends on bgbd_pkg and the battery_gauge_bar_display RTL.
`default_nettype none

module battery_gauge_bar_display_test;
  import bgbd_pkg::*;

  // Half of an 8-unit clock period.
  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 7;
  // The quiet limit allows for the time a sample needs inside the block, an input
  // gap and an output stall, several times over.
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 120;
  localparam int unsigned REPORT_LIMIT  = 10;
  // Five random phases of 135 samples, each under its own setting; the last one
  // runs with both streams at full speed.
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS   = 135;
  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd5;
  localparam int unsigned          SPARE_REGS      = 3;

  // One complete set of register values.
  typedef struct packed {
    logic [MV_W-1:0]  scale;
    logic [MV_W-1:0]  empty_mv;
    logic [MV_W-1:0]  full_mv;
    logic [PCT_W-1:0] red;
    logic [PCT_W-1:0] yellow;
  } gauge_setting_t;

  localparam gauge_setting_t RESET_SETTING = '{16'd7128, 16'd3200, 16'd4200, 7'd30, 7'd50};

  // Result fields as they sit in m_axis_tdata, the lowest field last.
  typedef struct packed {
    bar_color_e         colour;
    logic [LIT_W-1:0]   lit;
    logic [PCT_W-1:0]   average;
    logic [PCT_W-1:0]   instant;
  } gauge_reading_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    gauge_reading_t      reading;
  } gauge_expect_t;

  // The scoreboard keeps its own copy of the registers and of the averaging
  // window. Each accepted sample is turned into the reading the block must give,
  // and each result transaction is compared with the oldest reading still owed.
  class gauge_scoreboard;
    logic [MV_W-1:0]  full_scale;
    logic [MV_W-1:0]  empty_mv;
    logic [MV_W-1:0]  full_mv;
    logic [PCT_W-1:0] red_limit;
    logic [PCT_W-1:0] yellow_limit;
    logic [PCT_W-1:0] history [WINDOW_SIZE];
    int unsigned      wr_ptr;
    int unsigned      fill;
    int unsigned      sum;
    gauge_expect_t    owed [$];
    int unsigned      mismatches;
    int unsigned      unexpected;
    int unsigned      reported;

    function new();
      full_scale   = RESET_SETTING.scale;
      empty_mv     = RESET_SETTING.empty_mv;
      full_mv      = RESET_SETTING.full_mv;
      red_limit    = RESET_SETTING.red;
      yellow_limit = RESET_SETTING.yellow;
      wr_ptr       = 0;
      fill         = 0;
      sum          = 0;
      mismatches   = 0;
      unexpected   = 0;
      reported     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_MV_FULL_SCALE: full_scale   = value;
        REG_EMPTY_MV:      empty_mv     = value;
        REG_FULL_MV:       full_mv      = value;
        REG_RED_LIMIT:     red_limit    = value[PCT_W-1:0];
        REG_YELLOW_LIMIT:  yellow_limit = value[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned charge_percent(logic [SAMPLE_W-1:0] sample);
      int unsigned mv;
      int unsigned pct;
      mv = (int'(sample) * int'(full_scale)) / ADC_TOP;
      if (full_mv <= empty_mv || mv <= empty_mv) return 0;
      pct = ((mv - empty_mv) * PCT_MAX) / (full_mv - empty_mv);
      return (pct > PCT_MAX) ? PCT_MAX : pct;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] sample);
      gauge_expect_t e;
      int unsigned   pct;
      int unsigned   avg;
      pct = charge_percent(sample);
      // Once the window is full the oldest percent leaves the sum first.
      if (fill >= WINDOW_SIZE) sum -= history[wr_ptr];
      else fill++;
      history[wr_ptr] = PCT_W'(pct);
      sum += pct;
      wr_ptr = (wr_ptr + 1 == WINDOW_SIZE) ? 0 : wr_ptr + 1;
      avg = sum / fill;
      if (avg > PCT_MAX) avg = PCT_MAX;
      e.sample            = sample;
      e.reading.instant   = PCT_W'(pct);
      e.reading.average   = PCT_W'(avg);
      e.reading.lit       = LIT_W'((BAR_LEDS * avg) / PCT_MAX);
      if (avg == 0) e.reading.colour = BAR_OFF;
      else if (avg < red_limit) e.reading.colour = BAR_RED;
      else if (avg < yellow_limit) e.reading.colour = BAR_YELLOW;
      else e.reading.colour = BAR_GREEN;
      owed.push_back(e);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      gauge_reading_t got;
      gauge_expect_t  e;
      got = gauge_reading_t'(tdata[OUT_FIELD_W-1:0]);
      if (owed.size() == 0) begin
        unexpected++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("unexpected result: inst %0d avg %0d lit %0d colour %0d",
                   got.instant, got.average, got.lit, got.colour);
        end
        return;
      end
      e = owed.pop_front();
      if (got.instant !== e.reading.instant || got.average !== e.reading.average ||
          got.lit !== e.reading.lit || got.colour !== e.reading.colour) begin
        mismatches++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("mismatch for sample %0d: expected inst %0d avg %0d lit %0d colour %0d,",
                   e.sample, e.reading.instant, e.reading.average, e.reading.lit,
                   e.reading.colour);
          $display("  got inst %0d avg %0d lit %0d colour %0d",
                   got.instant, got.average, got.lit, got.colour);
        end
      end
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [11:0] adc_sample, [15:12] zero.
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [6:0] instant_percent, [13:7] average_percent, [16:14] lit_count,
  // [18:17] bar_color, [23:19] zero.
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;

  gauge_scoreboard gauge;
  // Random idling on both streams is switched off for the closing phase.
  bit              idling_on = 1'b1;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;

  battery_gauge_bar_display uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // The output side stalls in random bursts. Since a finished result waits in
  // the output register, a long stall also holds back the following sample,
  // which exercises back-pressure onto the input stream.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every result transaction is checked at the edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) gauge.check_result(m_axis_tdata);
  end

  // The watchdog ends a run in which no transaction completes on either stream
  // for far longer than the slowest correct sample could take.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[battery_gauge_bar_display] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one sample at a falling edge, possibly after an input gap, and holds
  // it until the block takes it. Valid stays high into the next call, so it is
  // only lowered when a gap really starts.
  task automatic push_sample(input logic [SAMPLE_W-1:0] sample);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(sample);
    do @(posedge clk_i); while (!s_axis_tready);
    gauge.note_sample(sample);
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every owed result has been taken, so that the
  // block holds no transaction and its registers may be changed.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (gauge.owed.size() != 0) @(negedge clk_i);
  endtask

  // Write enable is left high between back-to-back writes and lowered once the
  // whole group is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    gauge.write_reg(index, value);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input gauge_setting_t s);
    settle();
    write_reg(REG_MV_FULL_SCALE, s.scale);
    write_reg(REG_EMPTY_MV, s.empty_mv);
    write_reg(REG_FULL_MV, s.full_mv);
    write_reg(REG_RED_LIMIT, CFG_DATA_W'(s.red));
    write_reg(REG_YELLOW_LIMIT, CFG_DATA_W'(s.yellow));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly plausible battery settings, now and then an extreme full scale or an
  // empty voltage at or above the full voltage.
  function automatic gauge_setting_t random_setting();
    gauge_setting_t s;
    int unsigned    y;
    s.scale    = ($urandom_range(0, 7) == 0) ? 16'hFFFF : MV_W'($urandom_range(3000, 9000));
    s.empty_mv = MV_W'($urandom_range(1500, 4000));
    if ($urandom_range(0, 9) == 0) s.full_mv = s.empty_mv - MV_W'($urandom_range(0, 200));
    else s.full_mv = s.empty_mv + MV_W'($urandom_range(100, 1500));
    s.red = PCT_W'($urandom_range(0, PCT_MAX));
    y = s.red + $urandom_range(0, 50);
    if ($urandom_range(0, 5) == 0) y = $urandom_range(0, PCT_MAX);
    s.yellow = PCT_W'((y > PCT_MAX) ? PCT_MAX : y);
    return s;
  endfunction

  // Most samples land between the codes of the empty and full voltages, where
  // the percent actually moves; the rest are uniform or at the code extremes.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input gauge_setting_t s);
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    roll = $urandom_range(0, 19);
    if (roll < 5 || s.scale == 0) return SAMPLE_W'($urandom_range(0, ADC_TOP));
    if (roll < 7) return (roll == 5) ? SAMPLE_W'(ADC_TOP) : '0;
    lo = (s.empty_mv * ADC_TOP) / s.scale;
    hi = (s.full_mv * ADC_TOP) / s.scale + 1;
    if (lo > ADC_TOP) lo = ADC_TOP;
    if (hi > ADC_TOP) hi = ADC_TOP;
    return SAMPLE_W'($urandom_range(lo, hi));
  endfunction

  initial begin
    gauge = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: an all-empty start gives the colourless zero average, then
    // the converter extremes, samples either side of the empty voltage and one at full.
    push_sample('0);
    push_sample(SAMPLE_W'(ADC_TOP));
    push_sample(12'd1838);
    push_sample(12'd2100);
    push_sample(12'd2413);

    // Unit full scale, so the millivolts equal the code: a sample exactly at
    // the empty voltage, either side of it, at and above full, and alternating
    // bit patterns. Red below zero never fires; any nonzero average short of 100 is yellow.
    apply_setting('{16'd4095, 16'd1000, 16'd3000, 7'd0, 7'd100});
    push_sample(12'd1000);
    push_sample(12'd999);
    push_sample(12'd1001);
    push_sample(12'd3000);
    push_sample(12'd3001);
    push_sample(SAMPLE_W'(ADC_TOP));
    push_sample(12'hAAA);
    push_sample(12'h555);

    // Full equal to empty: every instant percent is zero.
    apply_setting('{16'hFFFF, 16'd2000, 16'd2000, 7'd100, 7'd100});
    push_sample(SAMPLE_W'(ADC_TOP));
    push_sample(12'h800);

    // Zero full scale and full below empty, with the limits out of order.
    apply_setting('{16'h0000, 16'hFFFF, 16'h0000, 7'd80, 7'd20});
    push_sample(SAMPLE_W'(ADC_TOP));
    push_sample(12'h7FF);

    // Widest span and limits above 100; writes to undecoded indexes must leave
    // every register alone.
    apply_setting('{16'hFFFF, 16'h0000, 16'hFFFF, 7'd127, 7'd127});
    for (int r = 0; r < SPARE_REGS; r++) write_reg(FIRST_SPARE_REG + CFG_IDX_W'(r), '1);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    push_sample(SAMPLE_W'(ADC_TOP));
    push_sample(12'h800);

    // Random phases, each under its own setting; the last one returns to the
    // reset values and runs with both streams at full speed.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      gauge_setting_t s;
      s = (ph == RANDOM_PHASES - 1) ? RESET_SETTING : random_setting();
      apply_setting(s);
      idling_on = (ph != RANDOM_PHASES - 1);
      repeat (PHASE_ITEMS) push_sample(pick_sample(s));
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (gauge.mismatches == 0 && gauge.unexpected == 0 && gauge.owed.size() == 0) begin
      $display("[battery_gauge_bar_display] OK");
    end else begin
      $display("[battery_gauge_bar_display] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/bgbd_pkg.sv
rtl/bgbd_serial_mul.sv
rtl/bgbd_serial_div.sv
rtl/bgbd_ring.sv
rtl/battery_gauge_bar_display.sv
rtl/bgbd_checker.sv
bench/battery_gauge_bar_display_test.sv
